/* rtl/trs_pkg.sv */
`timescale 1ns / 1ps
package trs_pkg;

	// Tile coordinate width, set by the fixed field widths
	localparam int COORD_BITS = 6;
	localparam int COLOUR_BITS = 32;
	localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [COLOUR_BITS-1:0] colour_t;
	typedef logic signed [COORD_BITS:0] delta_t;

	// One triangle as it arrives
	typedef struct packed {
		coord_t  vx0;
		coord_t  vy0;
		coord_t  vx1;
		coord_t  vy1;
		coord_t  vx2;
		coord_t  vy2;
		colour_t fill_colour;
	} tri_t;

	// One span as it leaves
	typedef struct packed {
		coord_t  span_row;
		coord_t  span_start;
		coord_t  span_end;
		colour_t span_colour;
		logic    last_span;
	} span_t;

	// Shape of a sorted triangle
	typedef enum logic [1:0] {
		KIND_LINE,
		KIND_DOWN,
		KIND_UP,
		KIND_SPLIT
	} kind_t;

	// Classified triangle handed from the front to the back
	typedef struct packed {
		coord_t                    x0;
		coord_t                    y0;
		coord_t                    x1;
		coord_t                    y1;
		coord_t                    x2;
		coord_t                    y2;
		colour_t                   colour;
		kind_t                     kind;
		logic [2*COORD_BITS-1:0]   num_mag;
		logic                      num_neg;
	} desc_t;

	// Back sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LINE,
		ST_MID,
		ST_DIV,
		ST_WALK
	} state_t;

	// Signed difference of two coordinates
	function automatic delta_t coord_diff(input coord_t a, input coord_t b);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	// Magnitude of a coordinate difference
	function automatic coord_t delta_mag(input delta_t d);
		delta_t n;
		n = -d;
		return d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
	endfunction

endpackage

/* rtl/trs_front.sv */
`timescale 1ns / 1ps
module trs_front import trs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  tri_valid,
	output logic  tri_stall,
	input  tri_t  triangle,
	output logic  push,
	output desc_t push_desc,
	input  logic  q_full
);

	logic   valid_s1;
	tri_t   tri_s1;
	coord_t xs [3];
	coord_t ys [3];
	delta_t dx02;
	coord_t dy01;
	kind_t  kind;

	assign tri_stall = valid_s1 & q_full;
	assign push = valid_s1 & ~q_full;

	// Hold the triangle until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tri_valid && !tri_stall) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tri_valid && !tri_stall) begin
			tri_s1 <= triangle;
		end
	end

	// Sort by y with three compare-and-swap steps; ties keep input order
	always_comb begin
		coord_t t;
		t = '0;
		xs[0] = tri_s1.vx0;
		ys[0] = tri_s1.vy0;
		xs[1] = tri_s1.vx1;
		ys[1] = tri_s1.vy1;
		xs[2] = tri_s1.vx2;
		ys[2] = tri_s1.vy2;
		if (ys[0] > ys[1]) begin
			t = ys[0]; ys[0] = ys[1]; ys[1] = t;
			t = xs[0]; xs[0] = xs[1]; xs[1] = t;
		end
		if (ys[1] > ys[2]) begin
			t = ys[1]; ys[1] = ys[2]; ys[2] = t;
			t = xs[1]; xs[1] = xs[2]; xs[2] = t;
		end
		if (ys[0] > ys[1]) begin
			t = ys[0]; ys[0] = ys[1]; ys[1] = t;
			t = xs[0]; xs[0] = xs[1]; xs[1] = t;
		end
	end

	// Classify the shape and form the split-point numerator
	always_comb begin
		if (ys[0] == ys[2]) begin
			kind = KIND_LINE;
		end else if (ys[1] == ys[2]) begin
			kind = KIND_DOWN;
		end else if (ys[0] == ys[1]) begin
			kind = KIND_UP;
		end else begin
			kind = KIND_SPLIT;
		end
		dx02 = coord_diff(xs[2], xs[0]);
		dy01 = ys[1] - ys[0];
		push_desc.x0 = xs[0];
		push_desc.y0 = ys[0];
		push_desc.x1 = xs[1];
		push_desc.y1 = ys[1];
		push_desc.x2 = xs[2];
		push_desc.y2 = ys[2];
		push_desc.colour = tri_s1.fill_colour;
		push_desc.kind = kind;
		push_desc.num_mag = (2*COORD_BITS)'(delta_mag(dx02)) * (2*COORD_BITS)'(dy01);
		push_desc.num_neg = dx02[COORD_BITS];
	end

endmodule

/* rtl/trs_fifo.sv */
`timescale 1ns / 1ps
module trs_fifo import trs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output desc_t head
);

	desc_t      mem_q [2];
	desc_t      head_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign head = head_q;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Write the entry and refill the head register
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
		if (push && (empty || (pop && count_q == 2'd1))) begin
			head_q <= push_desc;
		end else if (pop) begin
			head_q <= mem_q[~rd_ptr_q];
		end
	end

endmodule

/* rtl/trs_div.sv */
`timescale 1ns / 1ps
module trs_div import trs_pkg::*; #(
	parameter int DW = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  coord_t        divisor,
	output logic          done,
	output logic [DW-1:0] quotient,
	output logic          rem_nz
);

	localparam int CW = $clog2(DW);

	logic [DW-1:0]     quo_q;
	coord_t            rem_q;
	coord_t            dvs_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [COORD_BITS:0] trial;
	logic [COORD_BITS:0] diff;
	logic              ge;

	// One restoring step per cycle
	assign trial = {rem_q, quo_q[DW-1]};
	assign ge = trial >= {1'b0, dvs_q};
	assign diff = trial - {1'b0, dvs_q};

	assign done = done_q;
	assign quotient = quo_q;
	assign rem_nz = rem_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(DW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			cnt_q <= cnt_q + 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
		end
	end

endmodule

/* rtl/trs_back.sv */
`timescale 1ns / 1ps
module trs_back import trs_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_empty,
	input  desc_t q_head,
	output logic  pop,
	output logic  span_valid,
	input  logic  span_stall,
	output span_t span
);

	localparam int QW = COORD_BITS + FRAC_BITS;
	localparam int SW = QW + 1;
	localparam int EW = SW + 1;
	localparam int DW = (QW > 2*COORD_BITS) ? QW : 2*COORD_BITS;

	state_t                state_q;
	state_t                state_d;
	desc_t                 d_q;
	coord_t                mx_q;
	logic                  up_q;
	coord_t                row_q;
	coord_t                end_row_q;
	logic signed [EW-1:0]  edge_l_q;
	logic signed [EW-1:0]  edge_r_q;
	logic signed [SW-1:0]  step_l_q;
	logic signed [SW-1:0]  step_r_q;
	logic                  neg_l_q;
	logic                  neg_r_q;
	span_t                 span_q;
	logic                  span_valid_q;

	logic                  out_free;
	logic                  row_done;
	logic                  final_part;
	logic                  emit;
	logic                  div_start;
	logic                  div_done;
	logic                  use_num;
	delta_t                dl;
	delta_t                dr;
	coord_t                dvs;
	logic [DW-1:0]         dvd_l;
	logic [DW-1:0]         dvd_r;
	logic [DW-1:0]         quot_l;
	logic [DW-1:0]         quot_r;
	logic                  rem_nz_l;
	logic [COORD_BITS+1:0] mx_wide;
	coord_t                mx_new;
	logic signed [EW-1:0]  edge_lo;
	logic signed [EW-1:0]  edge_hi;
	span_t                 span_new;

	function automatic logic signed [SW-1:0] to_slope(input logic [QW-1:0] q, input logic neg);
		logic signed [SW-1:0] m;
		m = $signed({1'b0, q});
		return neg ? -m : m;
	endfunction

	// Truncate toward zero and clamp to the tile
	function automatic coord_t clamp_x(input logic signed [EW-1:0] v);
		logic [COORD_BITS:0] t;
		t = v[EW-2:FRAC_BITS];
		if (v[EW-1]) begin
			return '0;
		end else if (t[COORD_BITS]) begin
			return COORD_MAX;
		end else begin
			return t[COORD_BITS-1:0];
		end
	endfunction

	function automatic logic signed [EW-1:0] widen(input logic signed [SW-1:0] s);
		return {s[SW-1], s};
	endfunction

	assign out_free = ~span_valid_q | ~span_stall;
	assign row_done = row_q == end_row_q;
	assign final_part = up_q | (d_q.kind != KIND_SPLIT);
	assign span_valid = span_valid_q;
	assign span = span_q;

	// Two dividers run side by side, one per edge
	trs_div #(.DW(DW)) u_div_l (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_l),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quot_l),
		.rem_nz   (rem_nz_l)
	);

	trs_div #(.DW(DW)) u_div_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_r),
		.divisor  (dvs),
		.done     (),
		.quotient (quot_r),
		.rem_nz   ()
	);

	// Floor the split-point offset
	always_comb begin
		if (d_q.num_neg) begin
			mx_wide = {2'b00, d_q.x0} - {2'b00, quot_l[COORD_BITS-1:0]}
				- (COORD_BITS+2)'(rem_nz_l);
		end else begin
			mx_wide = {2'b00, d_q.x0} + {2'b00, quot_l[COORD_BITS-1:0]};
		end
		mx_new = mx_wide[COORD_BITS-1:0];
	end

	// Select divider operands
	always_comb begin
		use_num = 1'b0;
		dl = coord_diff(d_q.x2, d_q.x1);
		dr = coord_diff(d_q.x2, mx_q);
		dvs = d_q.y2 - d_q.y1;
		case (state_q)
			ST_IDLE: begin
				case (q_head.kind)
					KIND_SPLIT: begin
						use_num = 1'b1;
						dvs = q_head.y2 - q_head.y0;
					end
					KIND_DOWN: begin
						dl = coord_diff(q_head.x1, q_head.x0);
						dr = coord_diff(q_head.x2, q_head.x0);
						dvs = q_head.y2 - q_head.y0;
					end
					KIND_UP: begin
						dl = coord_diff(q_head.x2, q_head.x0);
						dr = coord_diff(q_head.x2, q_head.x1);
						dvs = q_head.y2 - q_head.y0;
					end
					default: begin
					end
				endcase
			end
			ST_MID: begin
				dl = coord_diff(d_q.x1, d_q.x0);
				dr = coord_diff(mx_new, d_q.x0);
				dvs = d_q.y1 - d_q.y0;
			end
			default: begin
			end
		endcase
		dvd_l = use_num ? DW'(q_head.num_mag) : DW'({delta_mag(dl), {FRAC_BITS{1'b0}}});
		dvd_r = use_num ? DW'(q_head.num_mag) : DW'({delta_mag(dr), {FRAC_BITS{1'b0}}});
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					case (q_head.kind)
						KIND_LINE:  state_d = ST_LINE;
						KIND_SPLIT: state_d = ST_MID;
						default:    state_d = ST_DIV;
					endcase
				end
			end
			ST_LINE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_MID: begin
				if (div_done) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (out_free && row_done) begin
					state_d = final_part ? ST_IDLE : ST_DIV;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		pop = 1'b0;
		div_start = 1'b0;
		emit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop = ~q_empty;
				div_start = ~q_empty & (q_head.kind != KIND_LINE);
			end
			ST_LINE: begin
				emit = out_free;
			end
			ST_MID: begin
				div_start = div_done;
			end
			ST_WALK: begin
				emit = out_free;
				div_start = out_free & row_done & ~final_part;
			end
			default: begin
			end
		endcase
	end

	// Form the next span
	always_comb begin
		edge_lo = (edge_l_q < edge_r_q) ? edge_l_q : edge_r_q;
		edge_hi = (edge_l_q < edge_r_q) ? edge_r_q : edge_l_q;
		span_new.span_colour = d_q.colour;
		if (state_q == ST_LINE) begin
			span_new.span_row = d_q.y0;
			span_new.span_start = d_q.x0;
			span_new.span_end = d_q.x0;
			if (d_q.x1 < span_new.span_start) span_new.span_start = d_q.x1;
			if (d_q.x2 < span_new.span_start) span_new.span_start = d_q.x2;
			if (d_q.x1 > span_new.span_end) span_new.span_end = d_q.x1;
			if (d_q.x2 > span_new.span_end) span_new.span_end = d_q.x2;
			span_new.last_span = 1'b1;
		end else begin
			span_new.span_row = row_q;
			span_new.span_start = clamp_x(edge_lo);
			span_new.span_end = clamp_x(edge_hi);
			span_new.last_span = row_done & final_part;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Track which half is being walked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q <= 1'b0;
		end else if (pop) begin
			up_q <= q_head.kind == KIND_UP;
		end else if (state_q == ST_WALK && emit && row_done && !final_part) begin
			up_q <= 1'b1;
		end
	end

	// Hold the span until it transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid_q <= 1'b0;
		end else if (emit) begin
			span_valid_q <= 1'b1;
		end else if (!span_stall) begin
			span_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			span_q <= span_new;
		end
	end

	// Edge walker datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			d_q <= q_head;
		end
		if (div_start) begin
			neg_l_q <= dl[COORD_BITS];
			neg_r_q <= dr[COORD_BITS];
		end
		if (state_q == ST_MID && div_done) begin
			mx_q <= mx_new;
		end
		if (state_q == ST_DIV && div_done) begin
			step_l_q <= to_slope(quot_l[QW-1:0], neg_l_q);
			step_r_q <= to_slope(quot_r[QW-1:0], neg_r_q);
			if (up_q) begin
				edge_l_q <= $signed({2'b00, d_q.x2, {FRAC_BITS{1'b0}}});
				edge_r_q <= $signed({2'b00, d_q.x2, {FRAC_BITS{1'b0}}});
				row_q <= d_q.y2;
				end_row_q <= (d_q.kind == KIND_SPLIT) ? d_q.y1 + 1'b1 : d_q.y0;
			end else begin
				edge_l_q <= $signed({2'b00, d_q.x0, {FRAC_BITS{1'b0}}});
				edge_r_q <= $signed({2'b00, d_q.x0, {FRAC_BITS{1'b0}}});
				row_q <= d_q.y0;
				end_row_q <= (d_q.kind == KIND_SPLIT) ? d_q.y1 : d_q.y2;
			end
		end else if (state_q == ST_WALK && emit && !row_done) begin
			if (up_q) begin
				row_q <= row_q - 1'b1;
				edge_l_q <= edge_l_q - widen(step_l_q);
				edge_r_q <= edge_r_q - widen(step_r_q);
			end else begin
				row_q <= row_q + 1'b1;
				edge_l_q <= edge_l_q + widen(step_l_q);
				edge_r_q <= edge_r_q + widen(step_r_q);
			end
		end
	end

`ifndef SYNTH
	a_down_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK && !up_q |-> row_q <= end_row_q)
		else $error("downward walk passed its last row");

	a_up_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK && up_q |-> row_q >= end_row_q)
		else $error("upward walk passed its last row");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_MID || state_q == ST_DIV)
		else $error("divider finished outside a divide state");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit && span_new.last_span |=> state_q == ST_IDLE)
		else $error("last span did not end the triangle");
`endif

endmodule

/* rtl/triangle_span_rasterizer_unit.sv */
`timescale 1ns / 1ps
// Channel    Direction  Handshake               Payload
// triangle   in         tri_valid / tri_stall   tri_t: three vertices and colour
// span       out        span_valid / span_stall span_t: row, start, end, colour, last
//
// A flat line gives one span. A flat-top or flat-bottom triangle runs one divide, then
// walks its rows; a general one divides for the split point, then divides and walks
// each half. DW = max(COORD_BITS + FRAC_BITS, 2 * COORD_BITS) (22 at the defaults) is
// the bit-serial divider length. Rows are emitted at one per cycle while spans transfer.
// Reset is asynchronous and needs no clearing pass. A two-entry queue lets the front
// accept triangles while the back walks; a waiting span holds the walk until it transfers.
module triangle_span_rasterizer_unit import trs_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  tri_valid,
	output logic  tri_stall,
	input  tri_t  triangle,
	output logic  span_valid,
	input  logic  span_stall,
	output span_t span
);

	logic  push;
	desc_t push_desc;
	logic  q_full;
	logic  q_empty;
	logic  pop;
	desc_t q_head;

	trs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.tri_valid (tri_valid),
		.tri_stall (tri_stall),
		.triangle  (triangle),
		.push      (push),
		.push_desc (push_desc),
		.q_full    (q_full)
	);

	trs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	trs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.pop        (pop),
		.span_valid (span_valid),
		.span_stall (span_stall),
		.span       (span)
	);

endmodule
